[design/huffman_tree_load_and_decode_core_macros.svh]
// assertion macros for the huffman tree load and decode core
`ifndef HUFFMAN_TREE_LOAD_AND_DECODE_CORE_MACROS_SVH
`define HUFFMAN_TREE_LOAD_AND_DECODE_CORE_MACROS_SVH

// implication checked every clock outside reset
`define HTLD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked every clock outside reset
`define HTLD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/htld_pkg.sv]
// ----------------------------------------------------------------------------
// htld_pkg
// types and codes shared by the huffman tree load and decode core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package htld_pkg;

  typedef enum logic [1:0] {
    CMD_BEGIN = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_FLUSH = 2'd2,
    CMD_NONE  = 2'd3
  } htld_cmd_t;

  typedef enum logic [1:0] {
    KIND_SYMBOL = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_ERROR  = 2'd2
  } htld_kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_LOAD   = 2'd1,
    MODE_DECODE = 2'd2
  } htld_mode_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,   // waiting for a transaction
    ST_BIT,    // issue reads for the current bit
    ST_EXEC,   // read data valid, act on bit
    ST_PLACE,  // write a child into the top open branch
    ST_EMIT,   // move a new result into the staging register
    ST_FIN     // release the staged result as the last one of the byte
  } htld_state_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] stream_byte;
  } htld_in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] symbol;
    logic       last;
  } htld_out_t;

  localparam logic [8:0] LEAF_FLAG = 9'h100;

endpackage

[design/huffman_tree_load_and_decode_core.sv]
// ----------------------------------------------------------------------------
// huffman_tree_load_and_decode_core
// rebuilds a pre-order serialized huffman tree and decodes the stream after it
// ----------------------------------------------------------------------------
// usage:
//   in_ channel: one transaction per command (begin, stream byte, flush).
//   out_ channel: one transaction per result (symbol, tree done, error); the
//   last result caused by an input has last set.
//   begin, flush, unused commands and bytes while idle are taken at once and
//   in_ready stays high, so they can follow each other with no gap.
//   a stream byte is walked one bit at a time, msb first: a store read, then
//   act, a place step when a child is written into its parent branch, an
//   emit step when a result is produced, plus the accept step and one
//   closing step. a byte holds in_ready low until its closing step, so the
//   next transaction is accepted only after that; the read of the branch
//   store and stack top for each bit sets the pace.
//   each result waits in a staging register until the next result or the end
//   of its byte shows whether it is the last one.
//   reset clears the mode, counters and stack depth; the stores need no
//   clearing pass since only written entries are ever read.
//   when the receiver stalls the sequencer holds at the pending result and
//   accepts no further input until the byte is finished.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module huffman_tree_load_and_decode_core #(
  parameter int MAX_BRANCHES = 255,
  parameter int MAX_LEAVES   = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  htld_pkg::htld_in_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output htld_pkg::htld_out_t out_data
);
  import htld_pkg::*;
`include "huffman_tree_load_and_decode_core_macros.svh"

  localparam int BW = 8;  // branch index width, up to 255 branches
  localparam int LW = 8;  // leaf index width, up to 256 leaves

  htld_state_t state_r, state_nxt;
  htld_mode_t  mode_r, mode_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [2:0]  bit_idx_r, bit_idx_nxt;   // index of the current bit
  logic [7:0]  stack_depth_r, stack_depth_nxt;
  logic [7:0]  branch_count_r, branch_count_nxt;
  logic [8:0]  leaf_count_r, leaf_count_nxt;
  logic [3:0]  leaf_bits_r, leaf_bits_nxt;
  logic [7:0]  leaf_partial_r, leaf_partial_nxt;
  logic [BW-1:0] walk_node_r, walk_node_nxt;
  // result waiting for the staging register
  htld_kind_t  pend_kind_r, pend_kind_nxt;
  // pending placement of a child into top branch
  logic [8:0]  place_ref_r, place_ref_nxt;
  logic        place_push_r, place_push_nxt; // child is a new branch to push
  // staging and output registers
  logic        stage_vld_r, stage_vld_nxt;
  htld_out_t   stage_r, stage_nxt;
  logic        out_valid_r;
  htld_out_t   out_data_r;
  logic        out_load;
  htld_out_t   out_load_data;
  logic [LW-1:0] lf_ra_r;

  // memory ports
  logic          br_we, lf_we, st_we;
  logic [BW-1:0] br_wa, br_ra, st_wa, st_ra;
  logic [17:0]   br_wd, br_rd;
  logic [LW-1:0] lf_wa, lf_ra;
  logic [7:0]    lf_wd, lf_rd;
  logic [8:0]    st_wd, st_rd;

  htld_store #(.DEPTH(1 << BW), .WIDTH(18)) u_branch (
    .clk(clk), .wr_en(br_we), .wr_addr(br_wa), .wr_data(br_wd),
    .rd_addr(br_ra), .rd_data(br_rd));
  htld_store #(.DEPTH(1 << LW), .WIDTH(8)) u_leaf (
    .clk(clk), .wr_en(lf_we), .wr_addr(lf_wa), .wr_data(lf_wd),
    .rd_addr(lf_ra), .rd_data(lf_rd));
  htld_store #(.DEPTH(1 << BW), .WIDTH(9)) u_stack (
    .clk(clk), .wr_en(st_we), .wr_addr(st_wa), .wr_data(st_wd),
    .rd_addr(st_ra), .rd_data(st_rd));

  logic cur_bit;
  logic [8:0] child;
  logic [7:0] leaf_shift;
  logic [7:0] depth_after;
  logic out_free;
  logic top_b_ok;
  logic step_bit;  // current bit done, go to the next one
  logic fail_bit;  // error found on the current bit

  assign cur_bit     = byte_r[bit_idx_r];
  assign child       = cur_bit ? br_rd[17:9] : br_rd[8:0];
  assign leaf_shift  = {leaf_partial_r[6:0], cur_bit};
  // stack depth once the child is placed (top popped when its zero side is set)
  assign depth_after = st_rd[8] ? stack_depth_r - 8'd1 : stack_depth_r;
  assign out_free    = !out_valid_r || out_ready;
  assign top_b_ok    = {1'b0, st_rd[7:0]} < 9'(MAX_BRANCHES);

  // next state, registers and memory controls
  always_comb begin
    state_nxt        = state_r;
    mode_nxt         = mode_r;
    byte_nxt         = byte_r;
    bit_idx_nxt      = bit_idx_r;
    stack_depth_nxt  = stack_depth_r;
    branch_count_nxt = branch_count_r;
    leaf_count_nxt   = leaf_count_r;
    leaf_bits_nxt    = leaf_bits_r;
    leaf_partial_nxt = leaf_partial_r;
    walk_node_nxt    = walk_node_r;
    pend_kind_nxt    = pend_kind_r;
    place_ref_nxt    = place_ref_r;
    place_push_nxt   = place_push_r;
    stage_vld_nxt    = stage_vld_r;
    stage_nxt        = stage_r;
    out_load         = 1'b0;
    step_bit         = 1'b0;
    fail_bit         = 1'b0;
    br_we = 1'b0; br_wa = '0; br_wd = '0; br_ra = walk_node_r;
    lf_we = 1'b0; lf_wa = leaf_count_r[LW-1:0]; lf_wd = '0; lf_ra = lf_ra_r;
    st_we = 1'b0; st_wa = '0; st_wd = '0;
    st_ra = stack_depth_r - 8'd1;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (htld_cmd_t'(in_data.command))
            CMD_BEGIN: begin
              stack_depth_nxt = '0; branch_count_nxt = '0; leaf_count_nxt = '0;
              leaf_bits_nxt = '0; leaf_partial_nxt = '0; walk_node_nxt = '0;
              mode_nxt = MODE_LOAD;
            end
            CMD_FLUSH: begin
              leaf_bits_nxt = '0; leaf_partial_nxt = '0; walk_node_nxt = '0;
              mode_nxt = MODE_IDLE;
            end
            CMD_BYTE: begin
              if (mode_r != MODE_IDLE) begin
                byte_nxt = in_data.stream_byte;
                bit_idx_nxt = 3'd7;
                state_nxt = ST_BIT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_BIT: begin
        // reads issued by default addresses (walk node, stack top)
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (mode_r == MODE_DECODE) begin
          if (child[8]) begin
            lf_ra = child[LW-1:0];
            walk_node_nxt = '0;
            pend_kind_nxt = KIND_SYMBOL;
            state_nxt = ST_EMIT;
          end else begin
            walk_node_nxt = child[BW-1:0];
            step_bit = 1'b1;
          end
        end else if (mode_r == MODE_LOAD) begin
          if (leaf_bits_r != 4'd0) begin
            // collecting the eight bits of a leaf byte
            leaf_partial_nxt = leaf_shift;
            leaf_bits_nxt = leaf_bits_r - 4'd1;
            if (leaf_bits_r != 4'd1) begin
              step_bit = 1'b1;
            end else if (leaf_count_r >= 9'(MAX_LEAVES)) begin
              fail_bit = 1'b1;
            end else begin
              lf_we = 1'b1;
              lf_wd = leaf_shift;
              leaf_count_nxt = leaf_count_r + 9'd1;
              place_ref_nxt = LEAF_FLAG | {1'b0, leaf_count_r[LW-1:0]};
              place_push_nxt = 1'b0;
              br_ra = st_rd[BW-1:0];
              state_nxt = ST_PLACE;
            end
          end else if (cur_bit) begin
            // leaf marker; a leaf with no open branch is a single-leaf tree
            if (leaf_count_r >= 9'(MAX_LEAVES) || stack_depth_r == 8'd0) begin
              fail_bit = 1'b1;
            end else begin
              leaf_bits_nxt = 4'd8; leaf_partial_nxt = '0;
              step_bit = 1'b1;
            end
          end else if (branch_count_r >= 8'(MAX_BRANCHES)) begin
            fail_bit = 1'b1;
          end else begin
            // new branch: clear it and write it one slot above the top
            br_we = 1'b1; br_wa = branch_count_r; br_wd = '0;
            st_we = 1'b1; st_wa = stack_depth_r; st_wd = {1'b0, branch_count_r};
            branch_count_nxt = branch_count_r + 8'd1;
            if (stack_depth_r == 8'd0) begin
              // root: the push is all there is
              stack_depth_nxt = 8'd1;
              step_bit = 1'b1;
            end else begin
              place_ref_nxt = {1'b0, branch_count_r};
              place_push_nxt = 1'b1;
              br_ra = st_rd[BW-1:0];
              state_nxt = ST_PLACE;
            end
          end
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_PLACE: begin
        // st_rd holds the top entry, br_rd holds that branch
        if (!top_b_ok) begin
          fail_bit = 1'b1;
        end else begin
          br_we = 1'b1; br_wa = st_rd[BW-1:0];
          if (st_rd[8]) br_wd = {place_ref_r, br_rd[8:0]};
          else br_wd = {br_rd[17:9], place_ref_r};
          st_we = 1'b1; st_wa = stack_depth_r - 8'd1;
          if (place_push_r) begin
            if (st_rd[8]) begin
              // top closes, the new branch takes its slot
              st_wd = {1'b0, place_ref_r[7:0]};
            end else begin
              // top gets its zero child, new branch already sits above it
              st_wd = {1'b1, st_rd[7:0]};
              stack_depth_nxt = stack_depth_r + 8'd1;
            end
            if (depth_after >= 8'(MAX_BRANCHES)) fail_bit = 1'b1;
            else step_bit = 1'b1;
          end else if (st_rd[8]) begin
            st_we = 1'b0;
            stack_depth_nxt = stack_depth_r - 8'd1;
            if (stack_depth_r == 8'd1) begin
              // root closed: tree complete
              pend_kind_nxt = KIND_DONE;
              mode_nxt = MODE_DECODE; walk_node_nxt = '0;
              state_nxt = ST_EMIT;
            end else begin
              step_bit = 1'b1;
            end
          end else begin
            st_wd = {1'b1, st_rd[7:0]};
            step_bit = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (!stage_vld_r || out_free) begin
          out_load = stage_vld_r;
          stage_vld_nxt = 1'b1;
          stage_nxt.kind = pend_kind_r;
          stage_nxt.symbol = (pend_kind_r == KIND_SYMBOL) ? lf_rd : 8'd0;
          stage_nxt.last = 1'b0;
          if (pend_kind_r == KIND_ERROR) state_nxt = ST_FIN;
          else step_bit = 1'b1;
        end
      end
      ST_FIN: begin
        if (!stage_vld_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_load = 1'b1;
          stage_vld_nxt = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    // an error ends the load and drops the rest of the byte
    if (fail_bit) begin
      pend_kind_nxt = KIND_ERROR;
      mode_nxt = MODE_IDLE; leaf_bits_nxt = '0;
      state_nxt = ST_EMIT;
    end
    if (step_bit) begin
      if (bit_idx_r == 3'd0) begin
        state_nxt = ST_FIN;
      end else begin
        bit_idx_nxt = bit_idx_r - 3'd1;
        state_nxt = ST_BIT;
      end
    end
  end

  // output register loading: last is known once the byte is finished
  always_comb begin
    out_load_data        = stage_r;
    out_load_data.last   = (state_r == ST_FIN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      mode_r         <= MODE_IDLE;
      stack_depth_r  <= '0;
      branch_count_r <= '0;
      leaf_count_r   <= '0;
      leaf_bits_r    <= '0;
      leaf_partial_r <= '0;
      walk_node_r    <= '0;
      stage_vld_r    <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      mode_r         <= mode_nxt;
      stack_depth_r  <= stack_depth_nxt;
      branch_count_r <= branch_count_nxt;
      leaf_count_r   <= leaf_count_nxt;
      leaf_bits_r    <= leaf_bits_nxt;
      leaf_partial_r <= leaf_partial_nxt;
      walk_node_r    <= walk_node_nxt;
      stage_vld_r    <= stage_vld_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    byte_r       <= byte_nxt;
    bit_idx_r    <= bit_idx_nxt;
    pend_kind_r  <= pend_kind_nxt;
    place_ref_r  <= place_ref_nxt;
    place_push_r <= place_push_nxt;
    stage_r      <= stage_nxt;
    lf_ra_r      <= lf_ra;
    if (out_load) out_data_r <= out_load_data;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `HTLD_ASSERT_IMP(a_depth_bound, 1'b1, stack_depth_r <= 8'(MAX_BRANCHES),
    "stack depth beyond store")
  `HTLD_ASSERT_IMP(a_leaf_bound, 1'b1, leaf_count_r <= 9'(MAX_LEAVES),
    "leaf count beyond store")
  `HTLD_ASSERT_IMP(a_idle_stage, state_r == ST_IDLE, !stage_vld_r,
    "result left in staging register while idle")
  `HTLD_ASSERT_NXT(a_out_hold, out_valid_r && !out_ready,
    out_valid_r && $stable(out_data_r), "result dropped or changed while stalled")
  `HTLD_ASSERT_IMP(a_err_last, out_valid_r && out_data_r.kind == KIND_ERROR,
    out_data_r.last, "error result without last")

endmodule

[design/htld_store.sv]
// ----------------------------------------------------------------------------
// htld_store
// synchronous memory with one write port, one read port and registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module htld_store #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 18
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
